FILE: sv/atma_pkg.sv
// ----------------------------------------------------------------------------
// atma_pkg
// Shared widths, constants and types for the temperature moving average.
// ----------------------------------------------------------------------------
package atma_pkg;

  localparam int READING_W  = 10;
  localparam int VREF_W     = 13;
  localparam int TEMP_W     = 16;
  localparam int ADC_SHIFT  = 10;
  localparam int WINDOW_DEF = 8;

  localparam logic [VREF_W-1:0] VREF_RESET = 13'd5000;

  typedef struct packed {
    logic rd;
    logic wr;
  } ring_ctl_t;

endpackage

FILE: sv/atma_ring.sv
// ----------------------------------------------------------------------------
// atma_ring
// Sample ring memory with write pointer, fill flag and running sum.
// ----------------------------------------------------------------------------
module atma_ring
  import atma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF,
  parameter int SUM_W  = TEMP_W + $clog2(WINDOW),
  parameter int CNT_W  = $clog2(WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  ring_ctl_t         ctl,
  input  logic [TEMP_W-1:0] temp,
  output logic [SUM_W-1:0]  sum,
  output logic [CNT_W-1:0]  count
);

  localparam int PTR_W = $clog2(WINDOW);

  logic [TEMP_W-1:0] mem [WINDOW];
  logic [TEMP_W-1:0] q;
  logic [PTR_W-1:0]  ptr;
  logic              full;
  logic [TEMP_W-1:0] old;
  logic [SUM_W-1:0]  sum_next;

  // entries are unwritten until the ring wraps; they read as zero
  assign old      = full ? q : '0;
  assign sum_next = sum - SUM_W'(old) + SUM_W'(temp);

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      q <= mem[ptr];
    end
    if (ctl.wr) begin
      mem[ptr] <= temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      full  <= 1'b0;
      sum   <= '0;
      count <= '0;
    end else if (ctl.wr) begin
      sum   <= sum_next;
      count <= full ? CNT_W'(WINDOW) : CNT_W'(ptr) + CNT_W'(1);
      if (ptr == PTR_W'(WINDOW - 1)) begin
        ptr  <= '0;
        full <= 1'b1;
      end else begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

endmodule

FILE: sv/atma_div.sv
// ----------------------------------------------------------------------------
// atma_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atma_div
  import atma_pkg::*;
#(
  parameter int SUM_W = TEMP_W + 3,
  parameter int CNT_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    trial;
  logic              ge;

  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign trial  = rem_sh - {1'b0, divisor};
  assign ge     = ~trial[CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= !start && busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule

FILE: sv/adc_temperature_moving_average.sv
// Each request runs through read, update, divider start, bit-serial divide and output load.
// No new request is taken until the result has been loaded into the output register.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous): vref_mv to 5000, pointer, fill flag and sum to zero.
// The ring memory is not cleared; the fill flag makes unwritten entries read as zero.
// ----------------------------------------------------------------------------
// adc_temperature_moving_average
// Scales converter readings to hundredths of a degree and keeps a boxcar mean.
// ----------------------------------------------------------------------------
module adc_temperature_moving_average
  import atma_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vref_we,
  input  logic [VREF_W-1:0]    vref_wdata,
  input  logic                 reading_valid,
  output logic                 reading_stall,
  input  logic [READING_W-1:0] adc_reading,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [TEMP_W-1:0]    current_temp,
  output logic [TEMP_W-1:0]    average_temp
);

  localparam int SUM_W  = TEMP_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int VX_W   = VREF_W + 4;
  localparam int PROD_W = READING_W + VX_W;
  localparam int SC_W   = PROD_W - ADC_SHIFT;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [VREF_W-1:0]    vref_mv;
  logic [READING_W-1:0] reading;
  logic [TEMP_W-1:0]    temp;
  logic [VX_W-1:0]      vref_x10;
  logic [PROD_W-1:0]    prod;
  logic [SC_W-1:0]      scaled;
  logic [TEMP_W-1:0]    temp_sat;
  logic                 accept;
  logic                 out_load;
  ring_ctl_t            ctl;
  logic [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]     count;
  logic                 div_done;
  logic [SUM_W-1:0]     quotient;

  assign accept        = reading_valid && !reading_stall;
  assign reading_stall = (state != S_IDLE);
  assign out_load      = (state == S_OUT) && (!result_valid || !result_stall);

  // reading * vref * 10 / 1024, saturated to 16 bits
  assign vref_x10 = VX_W'({vref_mv, 3'b000}) + VX_W'({vref_mv, 1'b0});
  assign prod     = PROD_W'(reading) * PROD_W'(vref_x10);
  assign scaled   = prod[PROD_W-1:ADC_SHIFT];
  assign temp_sat = (scaled[SC_W-1:TEMP_W] != '0) ? '1 : scaled[TEMP_W-1:0];

  assign ctl.rd = accept;
  assign ctl.wr = (state == S_UPD);

  atma_ring #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .temp  (temp),
    .sum   (sum),
    .count (count)
  );

  atma_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_RD;
      S_RD:    state_next = S_UPD;
      S_UPD:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_OUT;
      S_OUT:   if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vref_mv      <= VREF_RESET;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (vref_we) begin
        vref_mv <= vref_wdata;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      reading <= adc_reading;
    end
    if (state == S_RD) begin
      temp <= temp_sat;
    end
    if (out_load) begin
      current_temp <= temp;
      average_temp <= quotient[TEMP_W-1:0];
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RD)
    else $error("request accept did not start processing");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_mean_fits: assert property (@(posedge clk) disable iff (rst)
    div_done |-> quotient[SUM_W-1:TEMP_W] == '0)
    else $error("mean exceeds 16 bits, running sum inconsistent");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output state");

endmodule

FILE: test/tb_adc_temperature_moving_average.sv
// ----------------------------------------------------------------------------
// tb_adc_temperature_moving_average
// Self-checking bench for the scaled temperature boxcar average. Readings go
// in through a queue-fed driver. A mirror of the ring, sum and fill flag
// predicts each result. A monitor checks both temperatures in order while
// the reference setting changes between phases and, in most phases, both sides idle at random.
// ----------------------------------------------------------------------------
module tb_adc_temperature_moving_average;
  timeunit 1ns;
  timeprecision 1ps;
  import atma_pkg::*;

  typedef struct {
    logic [TEMP_W-1:0] current;
    logic [TEMP_W-1:0] average;
  } temp_pair_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 vref_we = 1'b0;
  logic [VREF_W-1:0]    vref_wdata = '0;
  logic                 reading_valid = 1'b0;
  logic                 reading_stall;
  logic [READING_W-1:0] adc_reading = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [TEMP_W-1:0]    current_temp;
  logic [TEMP_W-1:0]    average_temp;

  logic [READING_W-1:0] reading_q[$];
  temp_pair_t           temps_due_q[$];

  logic [VREF_W-1:0]    vref_mirror = VREF_RESET;
  logic [TEMP_W-1:0]    ring_mirror[WINDOW_DEF];
  int unsigned          sum_mirror = 0;
  int unsigned          slot_mirror = 0;
  bit                   full_mirror = 1'b0;

  bit                   idle_on = 1'b1;
  int                   fail_count = 0;
  int                   send_gap = 0;
  int                   recv_gap = 0;
  int                   long_hold = 0;
  int                   results_seen = 0;

  adc_temperature_moving_average DUT (
    .clk           (clk),
    .rst           (rst),
    .vref_we       (vref_we),
    .vref_wdata    (vref_wdata),
    .reading_valid (reading_valid),
    .reading_stall (reading_stall),
    .adc_reading   (adc_reading),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .current_temp  (current_temp),
    .average_temp  (average_temp)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    foreach (ring_mirror[i]) ring_mirror[i] = '0;
  end

  function automatic temp_pair_t average_of_reading(input logic [READING_W-1:0] reading);
    temp_pair_t  res;
    int unsigned scaled;
    int unsigned count;
    scaled = (int'(reading) * int'(vref_mirror) * 10) / 1024;
    if (scaled > 65535) scaled = 65535;
    sum_mirror = sum_mirror - ring_mirror[slot_mirror] + scaled;
    ring_mirror[slot_mirror] = scaled[TEMP_W-1:0];
    slot_mirror++;
    count = full_mirror ? WINDOW_DEF : slot_mirror;
    if (slot_mirror >= WINDOW_DEF) begin
      slot_mirror = 0;
      full_mirror = 1'b1;
    end
    res.current = scaled[TEMP_W-1:0];
    res.average = TEMP_W'(sum_mirror / count);
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      reading_valid <= 1'b0;
    end else begin
      if (reading_valid && !reading_stall) begin
        temps_due_q.push_back(average_of_reading(adc_reading));
      end
      if (!reading_valid || !reading_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          reading_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 11);
          reading_valid <= 1'b0;
        end else if (reading_q.size() != 0) begin
          reading_valid <= 1'b1;
          adc_reading <= reading_q.pop_front();
        end else begin
          reading_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    temp_pair_t due;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (temps_due_q.size() == 0) begin
          $error("unexpected result: current_temp %0d average_temp %0d",
                 current_temp, average_temp);
          fail_count++;
        end else begin
          due = temps_due_q.pop_front();
          if (current_temp !== due.current) begin
            $error("current_temp mismatch: expected %0d, got %0d", due.current, current_temp);
            fail_count++;
          end
          if (average_temp !== due.average) begin
            $error("average_temp mismatch: expected %0d, got %0d", due.average, average_temp);
            fail_count++;
          end
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 200 || results_seen == 700) long_hold = 250;
      end
      if (long_hold > 0) begin
        long_hold--;
        result_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 11);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained;
    while (reading_q.size() != 0 || reading_valid || temps_due_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vref(input logic [VREF_W-1:0] value);
    @(posedge clk);
    vref_we <= 1'b1;
    vref_wdata <= value;
    vref_mirror = value;
    @(posedge clk);
    vref_we <= 1'b0;
  endtask

  initial begin
    logic [VREF_W-1:0] phase_vref[10];
    int                pick;
    phase_vref[0] = 13'd5500;
    phase_vref[1] = 13'd1;
    phase_vref[2] = VREF_W'($urandom_range(1, 5500));
    phase_vref[3] = 13'd8191;
    phase_vref[4] = VREF_W'($urandom);
    phase_vref[5] = 13'd0;
    phase_vref[6] = VREF_W'($urandom_range(1, 5500));
    phase_vref[7] = VREF_W'($urandom);
    phase_vref[8] = 13'd5500;
    phase_vref[9] = VREF_W'($urandom_range(1, 5500));

    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset reference, warm-up through the first wrap
    reading_q = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'h155, 10'h2AA,
                  10'd1023, 10'd1023, 10'd1023};
    wait_drained();
    // scaled value saturates
    write_vref(13'd8191);
    reading_q = '{10'd1023, 10'd1022, 10'd820, 10'd0};
    wait_drained();
    // zero reference
    write_vref(13'd0);
    reading_q = '{10'd1023, 10'd555};
    wait_drained();
    write_vref(13'd1);
    reading_q = '{10'd1023, 10'd1};
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      write_vref(phase_vref[p]);
      idle_on = (p != 3 && p < 8);
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) reading_q.push_back('0);
        else if (pick == 1) reading_q.push_back('1);
        else reading_q.push_back(READING_W'($urandom_range(0, 1023)));
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0 && temps_due_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: adc_temperature_moving_average.f
sv/atma_pkg.sv
sv/atma_ring.sv
sv/atma_div.sv
sv/adc_temperature_moving_average.sv
test/tb_adc_temperature_moving_average.sv
